### rtl/tkf_pkg.sv
// Package with the constants, codes and word types of the terminal keystroke filter.
`timescale 1ns / 1ps

package tkf_pkg;

  localparam int EOL_SLOTS    = 4;
  localparam int EOL_REG_SLOTS = 4;
  localparam int CHAR_W       = 7;
  localparam int DEST_W       = 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int CFG_AW       = 6;
  localparam int CFG_DW       = 64;

  localparam logic [CHAR_W-1:0] CR_CHAR    = 7'h0D;
  localparam logic [CHAR_W-1:0] LF_CHAR    = 7'h0A;
  localparam logic [CHAR_W-1:0] LOWER_A    = 7'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z    = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 7'h20;

  localparam logic [CHAR_W-1:0] ESCAPE_RESET = 7'd126;
  localparam logic [CHAR_W-1:0] RAISE_RESET  = 7'd1;
  localparam logic [CHAR_W-1:0] FORCE_RESET  = 7'd16;

  typedef enum logic [DEST_W-1:0] {
    DEST_REMOTE = 2'd0,
    DEST_ECHO   = 2'd1,
    DEST_CMD    = 2'd2
  } dest_t;

  typedef enum logic [2:0] {
    REG_ESCAPE   = 3'd0,
    REG_RAISE    = 3'd1,
    REG_FORCE    = 3'd2,
    REG_EOL      = 3'd3,
    REG_CU_MODE  = 3'd4,
    REG_HALF_DUP = 3'd5,
    REG_CMD_LOW  = 3'd6,
    REG_CMD_HIGH = 3'd7
  } reg_idx_t;

  typedef struct packed {
    dest_t             dest;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

endpackage

### rtl/terminal_keystroke_filter.sv
// Terminal keystroke filter: flag tracking, result generation and result queue.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  in_      | slave     | tdata[7:0] key_char
//  out_     | master    | tdata[1:0] dest, tdata[8:2] out_char; tlast last
//  cfg_     | APB slave | 8 registers of up to 64 bits at byte address 8*i
//
// A word is accepted in every cycle in which the four-entry result queue holds
// at most one result; its zero to three results are written to the queue in
// that same cycle and leave one per cycle while out_tready is high, so a word
// yielding k results makes k output transfers. Reset is synchronous and restores
// the flags and registers and empties the queue; a stalled output stalls input.
`timescale 1ns / 1ps

module terminal_keystroke_filter
  import tkf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] key_char
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [1:0] dest, [8:2] out_char, rest zero
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CHAR_W-1:0] escape_r, raise_r, force_r;
  logic [31:0]       eol_r;
  logic              cu_mode_r, half_dup_r;
  logic [63:0]       cmd_low_r, cmd_high_r;

  logic at_line_start_r, raise_on_r, escape_pending_r, force_pending_r;
  logic at_line_start_nxt, raise_on_nxt, escape_pending_nxt, force_pending_nxt;

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r;

  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 in_acc, out_acc;
  logic [CHAR_W-1:0]    ch;
  logic [127:0]         cmd_mask;
  logic                 ch_eol, ch_cmd;
  result_t              res [3];
  logic [1:0]           n_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);

  always_comb begin
    case (cfg_idx)
      REG_ESCAPE:   cfg_prdata = {57'd0, escape_r};
      REG_RAISE:    cfg_prdata = {57'd0, raise_r};
      REG_FORCE:    cfg_prdata = {57'd0, force_r};
      REG_EOL:      cfg_prdata = {32'd0, eol_r};
      REG_CU_MODE:  cfg_prdata = {63'd0, cu_mode_r};
      REG_HALF_DUP: cfg_prdata = {63'd0, half_dup_r};
      REG_CMD_LOW:  cfg_prdata = cmd_low_r;
      REG_CMD_HIGH: cfg_prdata = cmd_high_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Room for the three results of any word, with one result still waiting.
  assign in_tready  = (cnt_r < (FIFO_AW+1)'(2));
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = {7'd0, mem_r[rd_ptr_r].ch, mem_r[rd_ptr_r].dest};
  assign out_tlast  = mem_r[rd_ptr_r].last;

  assign ch       = in_tdata[CHAR_W-1:0];
  assign cmd_mask = {cmd_high_r, cmd_low_r};
  assign ch_cmd   = (ch != '0) && cmd_mask[ch];

  always_comb begin
    ch_eol = 1'b0;
    for (int i = 0; i < EOL_SLOTS && i < EOL_REG_SLOTS; i++) begin
      if (eol_r[8*i +: 8] != 8'd0 && eol_r[8*i +: 8] == {1'b0, ch}) ch_eol = 1'b1;
    end
  end

  always_comb begin
    logic [CHAR_W-1:0] up;
    logic              do_ord;
    up = ch;
    if (raise_on_r && ch >= LOWER_A && ch <= LOWER_Z) up = ch - CASE_DELTA;
    do_ord             = 1'b0;
    n_res              = 2'd0;
    for (int k = 0; k < 3; k++) res[k] = '{dest: DEST_REMOTE, ch: '0, last: 1'b0};
    at_line_start_nxt  = at_line_start_r;
    raise_on_nxt       = raise_on_r;
    escape_pending_nxt = escape_pending_r;
    force_pending_nxt  = force_pending_r;

    if (escape_pending_r) begin
      escape_pending_nxt = 1'b0;
      if (ch_cmd) begin
        res[0] = '{dest: DEST_CMD, ch: ch, last: 1'b0};
        n_res  = 2'd1;
      end else begin
        if (escape_r != ch) begin
          res[0] = '{dest: DEST_REMOTE, ch: escape_r, last: 1'b0};
          n_res  = 2'd1;
        end
        do_ord = (ch != '0);
      end
    end else if (force_pending_r) begin
      force_pending_nxt = 1'b0;
      do_ord            = 1'b1;
    end else if (ch == escape_r && at_line_start_r) begin
      escape_pending_nxt = 1'b1;
    end else if (!cu_mode_r && ch == raise_r) begin
      raise_on_nxt = ~raise_on_r;
    end else if (ch == CR_CHAR) begin
      at_line_start_nxt = 1'b1;
      res[0] = '{dest: DEST_REMOTE, ch: CR_CHAR, last: 1'b0};
      res[1] = '{dest: DEST_ECHO, ch: CR_CHAR, last: 1'b0};
      res[2] = '{dest: DEST_ECHO, ch: LF_CHAR, last: 1'b0};
      n_res  = half_dup_r ? 2'd3 : 2'd1;
    end else if (!cu_mode_r && ch == force_r) begin
      force_pending_nxt = 1'b1;
    end else begin
      do_ord = 1'b1;
    end

    // Ordinary path appends after whatever the escape branch produced.
    if (do_ord) begin
      at_line_start_nxt = ch_eol;
      res[n_res] = '{dest: DEST_REMOTE, ch: up, last: 1'b0};
      if (half_dup_r) res[n_res + 2'd1] = '{dest: DEST_ECHO, ch: up, last: 1'b0};
      n_res = n_res + (half_dup_r ? 2'd2 : 2'd1);
    end

    for (int k = 0; k < 3; k++) begin
      if (2'(k) == n_res - 2'd1) res[k].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r         <= ESCAPE_RESET;
      raise_r          <= RAISE_RESET;
      force_r          <= FORCE_RESET;
      eol_r            <= '0;
      cu_mode_r        <= 1'b0;
      half_dup_r       <= 1'b0;
      cmd_low_r        <= '0;
      cmd_high_r       <= '0;
      at_line_start_r  <= 1'b1;
      raise_on_r       <= 1'b0;
      escape_pending_r <= 1'b0;
      force_pending_r  <= 1'b0;
      wr_ptr_r         <= '0;
      rd_ptr_r         <= '0;
      cnt_r            <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ESCAPE:   escape_r   <= cfg_pwdata[CHAR_W-1:0];
          REG_RAISE:    raise_r    <= cfg_pwdata[CHAR_W-1:0];
          REG_FORCE:    force_r    <= cfg_pwdata[CHAR_W-1:0];
          REG_EOL:      eol_r      <= cfg_pwdata[31:0];
          REG_CU_MODE:  cu_mode_r  <= cfg_pwdata[0];
          REG_HALF_DUP: half_dup_r <= cfg_pwdata[0];
          REG_CMD_LOW:  cmd_low_r  <= cfg_pwdata;
          REG_CMD_HIGH: cmd_high_r <= cfg_pwdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        at_line_start_r  <= at_line_start_nxt;
        raise_on_r       <= raise_on_nxt;
        escape_pending_r <= escape_pending_nxt;
        force_pending_r  <= force_pending_nxt;
        wr_ptr_r         <= wr_ptr_r + FIFO_AW'(n_res);
      end
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (in_acc ? (FIFO_AW+1)'(n_res) : '0) - (FIFO_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_res) mem_r[wr_ptr_r + FIFO_AW'(k)] <= res[k];
      end
    end
  end

endmodule
